// ----- rtl/core/optt_pkg.sv -----
// shared types, constants and helpers for the timer slot table
package optt_pkg;

    localparam int SLOTS       = 16;
    localparam int PERIOD_BITS = 16;
    localparam int TAG_BITS    = 16;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int IN_TAG_W    = 16;
    localparam int IN_PERIOD_W = 16;
    localparam int OUT_TAG_W   = 16;
    localparam int OUT_SLOT_W  = 4;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_REG  = 1'b1;

    localparam logic [1:0] MODE_ONESHOT = 2'd0;
    localparam logic [1:0] MODE_CYCLIC  = 2'd1;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_REJECTED = 3'd1,
        KIND_FULL     = 3'd2,
        KIND_FIRED    = 3'd3,
        KIND_NONE     = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REG,
        S_TICK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic                   action;
        logic [IN_TAG_W-1:0]    owner_tag;
        logic [IN_PERIOD_W-1:0] period_ticks;
        logic [1:0]             timer_mode;
    } t_in_item;

    typedef struct packed {
        t_kind                 result_kind;
        logic [OUT_TAG_W-1:0]  fired_tag;
        logic [OUT_SLOT_W-1:0] slot_index;
        logic                  last_of_run;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic reg_step;
        logic tick_step;
        logic flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_reg;
        logic in_bad;
        logic cur_valid;
        logic idx_last;
    } t_sts;

    function automatic logic [TAG_BITS-1:0] tag_store(input logic [IN_TAG_W-1:0] t);
        logic [TAG_BITS+IN_TAG_W-1:0] w;
        w = {{TAG_BITS{1'b0}}, t};
        return w[TAG_BITS-1:0];
    endfunction

    function automatic logic [OUT_TAG_W-1:0] tag_out(input logic [TAG_BITS-1:0] t);
        logic [TAG_BITS+OUT_TAG_W-1:0] w;
        w = {{OUT_TAG_W{1'b0}}, t};
        return w[OUT_TAG_W-1:0];
    endfunction

    function automatic logic [OUT_SLOT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+OUT_SLOT_W-1:0] w;
        w = {{OUT_SLOT_W{1'b0}}, s};
        return w[OUT_SLOT_W-1:0];
    endfunction

    // saturate an input period to the stored width
    function automatic logic [PERIOD_BITS-1:0] period_store(
        input logic [IN_PERIOD_W-1:0] p
    );
        logic [PERIOD_BITS+IN_PERIOD_W-1:0] w;
        logic [PERIOD_BITS+IN_PERIOD_W-1:0] pmax;
        w    = {{PERIOD_BITS{1'b0}}, p};
        pmax = {{IN_PERIOD_W{1'b0}}, {PERIOD_BITS{1'b1}}};
        if (w > pmax) begin
            return {PERIOD_BITS{1'b1}};
        end
        return w[PERIOD_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/optt_ctrl.sv -----
// controller state machine for the timer slot table
module optt_ctrl
    import optt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    // a bad registration is answered straight from the load
                    if (i_sts.in_reg && i_sts.in_bad) begin
                        n_state = S_IDLE;
                    end else if (i_sts.in_reg) begin
                        n_state = S_REG;
                    end else begin
                        n_state = S_TICK;
                    end
                end
            end
            S_REG: begin
                o_cmd.reg_step = 1'b1;
                if (!i_sts.cur_valid || i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/optt_dpath.sv -----
// slot storage, scan index and result register for the timer slot table
module optt_dpath
    import optt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_result,
    output logic      o_strobe
);

    logic [IN_TAG_W-1:0]    r_tag_in;
    logic [IN_PERIOD_W-1:0] r_period_in;
    logic                   r_cyc_in;
    logic [SLOT_W-1:0]      r_idx;

    logic [SLOTS-1:0]       r_valid;
    logic                   r_cyclic [SLOTS];
    logic [PERIOD_BITS-1:0] r_period [SLOTS];
    logic [PERIOD_BITS-1:0] r_count  [SLOTS];
    logic [TAG_BITS-1:0]    r_tag    [SLOTS];

    // one fired word held back until we know whether it is the last
    logic                   r_pend_vld;
    logic [TAG_BITS-1:0]    r_pend_tag;
    logic [SLOT_W-1:0]      r_pend_slot;

    t_out_item              r_out;
    logic                   r_strobe;

    logic [PERIOD_BITS-1:0] cnt_inc;
    logic                   idx_last;

    assign idx_last = (r_idx == SLOT_W'(SLOTS - 1));
    assign cnt_inc  = r_count[r_idx] + PERIOD_BITS'(1);

    assign o_sts.in_reg    = (i_item.action == ACT_REG);
    assign o_sts.in_bad    = (i_item.period_ticks == '0) || (i_item.timer_mode > MODE_CYCLIC);
    assign o_sts.cur_valid = r_valid[r_idx];
    assign o_sts.idx_last  = idx_last;

    assign o_result = r_out;
    assign o_strobe = r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_strobe   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cmd.load) begin
                r_tag_in    <= i_item.owner_tag;
                r_period_in <= i_item.period_ticks;
                r_cyc_in    <= (i_item.timer_mode == MODE_CYCLIC);
                r_idx       <= '0;
                r_pend_vld  <= 1'b0;
                if (o_sts.in_reg && o_sts.in_bad) begin
                    r_strobe          <= 1'b1;
                    r_out.result_kind <= KIND_REJECTED;
                    r_out.fired_tag   <= i_item.owner_tag;
                    r_out.slot_index  <= '0;
                    r_out.last_of_run <= 1'b1;
                end
            end
            if (i_cmd.reg_step) begin
                if (!r_valid[r_idx]) begin
                    r_valid[r_idx]    <= 1'b1;
                    r_cyclic[r_idx]   <= r_cyc_in;
                    r_period[r_idx]   <= period_store(r_period_in);
                    r_count[r_idx]    <= '0;
                    r_tag[r_idx]      <= tag_store(r_tag_in);
                    r_strobe          <= 1'b1;
                    r_out.result_kind <= KIND_ACCEPTED;
                    r_out.fired_tag   <= tag_out(tag_store(r_tag_in));
                    r_out.slot_index  <= slot_out(r_idx);
                    r_out.last_of_run <= 1'b1;
                end else if (idx_last) begin
                    r_strobe          <= 1'b1;
                    r_out.result_kind <= KIND_FULL;
                    r_out.fired_tag   <= r_tag_in;
                    r_out.slot_index  <= '0;
                    r_out.last_of_run <= 1'b1;
                end else begin
                    r_idx <= r_idx + SLOT_W'(1);
                end
            end
            if (i_cmd.tick_step) begin
                if (!idx_last) begin
                    r_idx <= r_idx + SLOT_W'(1);
                end
                if (r_valid[r_idx]) begin
                    if (cnt_inc == r_period[r_idx]) begin
                        if (r_cyclic[r_idx]) begin
                            r_count[r_idx] <= '0;
                        end else begin
                            r_valid[r_idx] <= 1'b0;
                        end
                        if (r_pend_vld) begin
                            r_strobe          <= 1'b1;
                            r_out.result_kind <= KIND_FIRED;
                            r_out.fired_tag   <= tag_out(r_pend_tag);
                            r_out.slot_index  <= slot_out(r_pend_slot);
                            r_out.last_of_run <= 1'b0;
                        end
                        r_pend_vld  <= 1'b1;
                        r_pend_tag  <= r_tag[r_idx];
                        r_pend_slot <= r_idx;
                    end else begin
                        r_count[r_idx] <= cnt_inc;
                    end
                end
            end
            if (i_cmd.flush) begin
                r_strobe          <= 1'b1;
                r_out.last_of_run <= 1'b1;
                r_pend_vld        <= 1'b0;
                if (r_pend_vld) begin
                    r_out.result_kind <= KIND_FIRED;
                    r_out.fired_tag   <= tag_out(r_pend_tag);
                    r_out.slot_index  <= slot_out(r_pend_slot);
                end else begin
                    r_out.result_kind <= KIND_NONE;
                    r_out.fired_tag   <= '0;
                    r_out.slot_index  <= '0;
                end
            end
        end
    end

endmodule

// ----- rtl/core/oneshot_periodic_timer_table.sv -----
// top level of the timer slot table with one-shot and cyclic timers
//
// a word on i_item is taken at a rising edge with start high and busy low.
// action selects a tick or a registration; results leave on o_result, each
// for one cycle with o_strobe high, and the last word of an item has
// last_of_run set. the receiver cannot stall, so no result is ever held.
// a registration scans the slots from slot 0 for the first free one, one
// slot a cycle: a zero period or bad mode is answered in the cycle after
// the start, otherwise the status comes once the free slot is reached,
// and a full table answers once the last slot is found in use.
// a tick visits every slot, one per cycle, through the same scan index;
// fired words come out during the scan in ascending slot order, the
// final one (or the single "none" word) from the flush state that
// follows the scan. busy stays high for the whole scan and the flush,
// so the next word can be taken as soon as busy is low.
// reset, sampled at the clock edge, empties the table (valid bits only) and returns to idle.
module oneshot_periodic_timer_table
    import optt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output t_out_item o_result,
    output logic      o_strobe
);

    t_cmd cmd;
    t_sts sts;

    optt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    optt_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule

// ----- bench/tb.sv -----
// self-checking bench for the timer slot table: directed and random registrations and ticks
module tb
    import optt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;

    // keeps its own copy of the slot table and the words each item must produce
    class timer_table_scoreboard;
        bit                     slot_used    [SLOTS];
        bit                     slot_loops   [SLOTS];
        logic [PERIOD_BITS-1:0] slot_len     [SLOTS];
        logic [PERIOD_BITS-1:0] slot_elapsed [SLOTS];
        logic [TAG_BITS-1:0]    slot_owner   [SLOTS];
        t_out_item              due_q[$];
        int                     mismatches;
        int                     regs_seen;
        int                     ticks_seen;
        int                     fulls_seen;
        int                     fires_seen;
        int                     words_seen;

        function new();
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
            end
            mismatches = 0;
            regs_seen  = 0;
            ticks_seen = 0;
            fulls_seen = 0;
            fires_seen = 0;
            words_seen = 0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // work out the words one accepted input word causes
        function void note_word(t_in_item w);
            t_out_item r;
            t_out_item held;
            bit        have_held;
            int        free_slot;
            r         = '0;
            held      = '0;
            have_held = 1'b0;
            free_slot = -1;
            if (w.action == ACT_REG) begin
                regs_seen++;
                r.fired_tag   = w.owner_tag;
                r.last_of_run = 1'b1;
                if (w.period_ticks == '0 ||
                    (w.timer_mode != MODE_ONESHOT && w.timer_mode != MODE_CYCLIC)) begin
                    r.result_kind = KIND_REJECTED;
                end else begin
                    for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (!slot_used[i]) free_slot = i;
                    end
                    if (free_slot < 0) begin
                        r.result_kind = KIND_FULL;
                        fulls_seen++;
                    end else begin
                        slot_used[free_slot]    = 1'b1;
                        slot_loops[free_slot]   = (w.timer_mode == MODE_CYCLIC);
                        slot_len[free_slot]     = w.period_ticks;
                        slot_elapsed[free_slot] = '0;
                        slot_owner[free_slot]   = w.owner_tag;
                        r.result_kind = KIND_ACCEPTED;
                        r.fired_tag   = slot_owner[free_slot];
                        r.slot_index  = OUT_SLOT_W'(free_slot);
                    end
                end
                due_q.push_back(r);
            end else begin
                ticks_seen++;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i]) begin
                        slot_elapsed[i] = slot_elapsed[i] + 1'b1;
                        if (slot_elapsed[i] == slot_len[i]) begin
                            // hold each firing back one slot so the last one can be marked
                            if (have_held) due_q.push_back(held);
                            held             = '0;
                            held.result_kind = KIND_FIRED;
                            held.fired_tag   = slot_owner[i];
                            held.slot_index  = OUT_SLOT_W'(i);
                            have_held        = 1'b1;
                            fires_seen++;
                            if (slot_loops[i]) slot_elapsed[i] = '0;
                            else slot_used[i] = 1'b0;
                        end
                    end
                end
                if (have_held) begin
                    held.last_of_run = 1'b1;
                    due_q.push_back(held);
                end else begin
                    r.result_kind = KIND_NONE;
                    r.last_of_run = 1'b1;
                    due_q.push_back(r);
                end
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= 50) begin
                $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
            end
        endtask

        task check_word(t_out_item got);
            t_out_item want;
            words_seen++;
            if (due_q.size() == 0) begin
                report("unexpected result word", 32'(got), 32'(0));
                return;
            end
            want = due_q.pop_front();
            if (got.result_kind !== want.result_kind)
                report("result_kind", 32'(got.result_kind), 32'(want.result_kind));
            if (got.fired_tag !== want.fired_tag)
                report("fired_tag", 32'(got.fired_tag), 32'(want.fired_tag));
            if (got.slot_index !== want.slot_index)
                report("slot_index", 32'(got.slot_index), 32'(want.slot_index));
            if (got.last_of_run !== want.last_of_run)
                report("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    t_out_item o_result;
    logic      o_strobe;

    timer_table_scoreboard sb;
    int                    calm_left;

    oneshot_periodic_timer_table i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_in_item make_word(logic act, logic [15:0] tag, logic [15:0] len,
                                           logic [1:0] mode);
        t_in_item w;
        w.action       = act;
        w.owner_tag    = tag;
        w.period_ticks = len;
        w.timer_mode   = mode;
        return w;
    endfunction

    // mostly short gaps, a few long ones, and now and then a run with none at all
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            calm_left = $urandom_range(5, 15);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic t_in_item random_word();
        t_in_item w;
        int       p;
        w.owner_tag    = 16'($urandom);
        w.period_ticks = 16'($urandom_range(1, 6));
        w.timer_mode   = ($urandom_range(0, 99) < 35) ? MODE_CYCLIC : MODE_ONESHOT;
        p = $urandom_range(0, 99);
        if (p < 52) begin
            // tick words carry random junk in the unused fields
            w.action       = ACT_TICK;
            w.period_ticks = 16'($urandom);
            w.timer_mode   = 2'($urandom);
        end else begin
            w.action = ACT_REG;
            if (p < 58) begin
                w.period_ticks = 16'($urandom);
            end else if (p < 64) begin
                if ($urandom_range(0, 1)) w.period_ticks = '0;
                else w.timer_mode = {1'b1, 1'($urandom)};   // top bit set: illegal mode
            end
        end
        return w;
    endfunction

    // hold the word on the bus until the block takes it, then idle for a random gap, which may be zero
    task automatic send_word(t_in_item w);
        int gap;
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check_word(o_result);
            if (start && !busy) sb.note_word(i_item);
        end
    end

    // ends the run if neither side moves a word for too long
    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe) stall = 0;
            else stall++;
        end
        $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        sb        = new();
        calm_left = 0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_item    = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty tick, rejections, field extremes, slot reuse, full table
        send_word(make_word(ACT_TICK, 16'h0000, 16'h0000, MODE_ONESHOT));
        send_word(make_word(ACT_REG, 16'h1234, 16'h0000, MODE_ONESHOT));
        send_word(make_word(ACT_REG, 16'h4321, 16'h0003, 2'b10));
        send_word(make_word(ACT_REG, 16'h8001, 16'h0003, 2'b11));
        send_word(make_word(ACT_REG, 16'hFFFF, 16'h0001, MODE_ONESHOT));
        send_word(make_word(ACT_REG, 16'h0000, 16'hFFFF, MODE_CYCLIC));
        send_word(make_word(ACT_REG, 16'hA5A5, 16'h0002, MODE_CYCLIC));
        send_word(make_word(ACT_TICK, 16'hFFFF, 16'hFFFF, 2'b11));
        send_word(make_word(ACT_TICK, 16'h0000, 16'h0000, MODE_ONESHOT));
        send_word(make_word(ACT_REG, 16'h5A5A, 16'h0001, MODE_CYCLIC));
        for (int k = 3; k < SLOTS; k++) begin
            send_word(make_word(ACT_REG, 16'h1000 + 16'(k * 16'h0111), 16'h0001,
                                MODE_ONESHOT));
        end
        send_word(make_word(ACT_REG, 16'hBEEF, 16'h0004, MODE_CYCLIC));
        send_word(make_word(ACT_TICK, 16'h0000, 16'h0000, MODE_ONESHOT));

        for (int n = 0; n < 95; n++) begin
            send_word(random_word());
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);

        $display("covered %0d registrations (%0d refused as full) and %0d ticks",
                 sb.regs_seen, sb.fulls_seen, sb.ticks_seen);
        $display("checked %0d result words, %0d of them firings; %0d mismatches",
                 sb.words_seen, sb.fires_seen, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/optt_pkg.sv
rtl/core/optt_ctrl.sv
rtl/core/optt_dpath.sv
rtl/core/oneshot_periodic_timer_table.sv
bench/tb.sv
